FILE: sv/srtc_pkg.sv
// Shared types, codes and constants of the serial read timeout controller.
// No dependencies.
package srtc_pkg;

  localparam int unsigned WORD_W           = 32;
  localparam int unsigned LENGTH_WIDTH_DEF = 16;
  localparam logic [WORD_W-1:0] ALL_ONES   = {WORD_W{1'b1}};

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_ARRIVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_ABORT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_DONE     = 3'd1,
    ST_TIMEOUT  = 3'd2,
    ST_CANCEL   = 3'd3,
    ST_NOACCESS = 3'd4,
    ST_BADLEN   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    MODE_FOREVER  = 4'b0001,
    MODE_INTERVAL = 4'b0010,
    MODE_ANYBYTE  = 4'b0100,
    MODE_GENERAL  = 4'b1000
  } mode_t;

  typedef enum logic [1:0] {
    CFG_READ_ALLOWED     = 2'd0,
    CFG_INTERVAL_TIMEOUT = 2'd1,
    CFG_TOTAL_MULTIPLIER = 2'd2,
    CFG_TOTAL_CONSTANT   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              read_allowed;
    logic [WORD_W-1:0] interval_timeout;
    logic [WORD_W-1:0] total_multiplier;
    logic [WORD_W-1:0] total_constant;
  } cfg_t;

endpackage

FILE: sv/srtc_limit.sv
// Saturating total read limit: constant + multiplier * length.
// Depends on srtc_pkg.
module srtc_limit import srtc_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  cfg_t                    cfg,
  input  logic [LENGTH_WIDTH-1:0] len,
  output logic [WORD_W-1:0]       lim
);

  localparam int unsigned PW = WORD_W + LENGTH_WIDTH;

  logic [PW-1:0] prod;
  logic [PW:0]   sum;

  assign prod = PW'(cfg.total_multiplier) * PW'(len);
  assign sum  = {1'b0, prod} + (PW + 1)'(cfg.total_constant);

  // all-ones multiplier means no limit at all
  always_comb begin
    if (cfg.total_multiplier == ALL_ONES) begin
      lim = ALL_ONES;
    end else if (sum[PW:WORD_W] != '0) begin
      lim = ALL_ONES;
    end else begin
      lim = sum[WORD_W-1:0];
    end
  end

endmodule

FILE: sv/srtc_ctrl.sv
// Read request state and per-item event handling (start, arrival, tick, abort).
// Depends on srtc_pkg; total limit comes from srtc_limit.
module srtc_ctrl import srtc_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    go,
  input  op_t                     op,
  input  logic [LENGTH_WIDTH-1:0] len,
  input  logic [LENGTH_WIDTH-1:0] cnt,
  input  cfg_t                    cfg,
  input  logic [WORD_W-1:0]       lim,
  output status_t                 res_status,
  output logic [LENGTH_WIDTH-1:0] res_bytes,
  output logic [WORD_W-1:0]       res_limit
);

  logic                    busy_r, busy_nxt;
  logic [LENGTH_WIDTH-1:0] requested_r, requested_nxt;
  logic [LENGTH_WIDTH-1:0] delivered_r, delivered_nxt;
  logic [WORD_W-1:0]       elapsed_r, elapsed_nxt;
  logic [WORD_W-1:0]       idle_r, idle_nxt;
  logic [WORD_W-1:0]       limit_r, limit_nxt;
  logic [WORD_W-1:0]       wait_r, wait_nxt;
  mode_t                   mode_r, mode_nxt;

  logic [LENGTH_WIDTH-1:0] room, add, start_del;
  logic [WORD_W-1:0]       elapsed_inc, idle_inc;
  logic                    lim_zero, any_byte, tmo;
  status_t                 st;

  assign room        = requested_r - delivered_r;
  assign add         = (cnt < room) ? cnt : room;
  assign start_del   = (cnt < len) ? cnt : len;
  assign elapsed_inc = (elapsed_r == ALL_ONES) ? elapsed_r : elapsed_r + WORD_W'(1);
  assign idle_inc    = (idle_r == ALL_ONES) ? idle_r : idle_r + WORD_W'(1);

  // length is non-zero on a real start, so a zero limit needs both terms zero
  assign lim_zero = (cfg.total_multiplier == '0) && (cfg.total_constant == '0);
  assign any_byte = (cfg.interval_timeout == ALL_ONES) && (cfg.total_multiplier == ALL_ONES)
                    && (cfg.total_constant != '0) && (cfg.total_constant != ALL_ONES);

  // timeout check on the post-tick counters
  always_comb begin
    case (mode_r)
      MODE_INTERVAL: tmo = (delivered_r != '0) && (idle_inc >= wait_r);
      MODE_ANYBYTE:  tmo = (idle_inc >= wait_r);
      MODE_GENERAL:  tmo = ((limit_r != ALL_ONES) && (elapsed_inc >= limit_r))
                           || ((delivered_r != '0) && (wait_r != '0)
                               && (wait_r != ALL_ONES) && (idle_inc >= wait_r));
      default:       tmo = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt      = busy_r;
    requested_nxt = requested_r;
    delivered_nxt = delivered_r;
    elapsed_nxt   = elapsed_r;
    idle_nxt      = idle_r;
    limit_nxt     = limit_r;
    wait_nxt      = wait_r;
    mode_nxt      = mode_r;
    st            = ST_PENDING;
    res_bytes     = delivered_r;
    res_limit     = limit_r;

    case (op)
      OP_START: begin
        if (len == '0) begin
          st        = ST_BADLEN;
          res_bytes = '0;
          res_limit = '0;
        end else if (!cfg.read_allowed) begin
          st        = ST_NOACCESS;
          res_bytes = '0;
          res_limit = lim;
        end else begin
          requested_nxt = len;
          delivered_nxt = start_del;
          elapsed_nxt   = '0;
          idle_nxt      = '0;
          limit_nxt     = lim;
          wait_nxt      = cfg.interval_timeout;
          if (lim_zero) begin
            mode_nxt = (cfg.interval_timeout == '0) ? MODE_FOREVER : MODE_INTERVAL;
          end else if (any_byte) begin
            mode_nxt = MODE_ANYBYTE;
            wait_nxt = cfg.total_constant;
          end else begin
            mode_nxt = MODE_GENERAL;
          end
          if (lim_zero && (cfg.interval_timeout == ALL_ONES)) begin
            st = ST_DONE;
          end else if (start_del == len) begin
            st = ST_DONE;
          end else if ((mode_nxt == MODE_ANYBYTE) && (start_del != '0)) begin
            st = ST_DONE;
          end
          busy_nxt  = (st == ST_PENDING);
          res_bytes = start_del;
          res_limit = lim;
        end
      end
      OP_ARRIVE: begin
        if (busy_r) begin
          delivered_nxt = delivered_r + add;
          idle_nxt      = '0;
          if ((delivered_nxt == requested_r)
              || ((mode_r == MODE_ANYBYTE) && (delivered_nxt != '0))) begin
            st = ST_DONE;
          end
          busy_nxt  = (st == ST_PENDING);
          res_bytes = delivered_nxt;
        end
      end
      OP_TICK: begin
        if (busy_r) begin
          elapsed_nxt = elapsed_inc;
          idle_nxt    = idle_inc;
          if (tmo) begin
            st = ST_TIMEOUT;
          end
          busy_nxt = !tmo;
        end
      end
      OP_ABORT: begin
        if (busy_r) begin
          st       = ST_CANCEL;
          busy_nxt = 1'b0;
        end
      end
      default: begin
        st = ST_PENDING;
      end
    endcase
  end

  assign res_status = st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      requested_r <= '0;
      delivered_r <= '0;
      elapsed_r   <= '0;
      idle_r      <= '0;
      limit_r     <= '0;
      wait_r      <= '0;
      mode_r      <= MODE_FOREVER;
    end else if (go) begin
      busy_r      <= busy_nxt;
      requested_r <= requested_nxt;
      delivered_r <= delivered_nxt;
      elapsed_r   <= elapsed_nxt;
      idle_r      <= idle_nxt;
      limit_r     <= limit_nxt;
      wait_r      <= wait_nxt;
      mode_r      <= mode_nxt;
    end
  end

`ifndef SYNTHESIS
  // a final answer always closes the read; rejected starts leave busy as it was
  a_final_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go && (st != ST_PENDING) && (st != ST_BADLEN) && (st != ST_NOACCESS) |=> !busy_r)
    else $error("read still busy after final status");

  // delivered count never passes the request while a read is open
  a_deliv_capped: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (delivered_r <= requested_r))
    else $error("delivered exceeds requested");

  // rejected starts leave the open read alone
  a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    go && (op == OP_START) && ((len == '0) || !cfg.read_allowed)
    |=> $stable(busy_r) && $stable(requested_r) && $stable(delivered_r))
    else $error("rejected start changed read state");
`endif

endmodule

FILE: sv/serial_read_timeout_controller.sv
// Serial read timeout controller: an accepted input item waits in the input register, then
// the event logic writes its result into the result register once that register is free or
// being emptied.
// Throughput one item per cycle; a stalled result holds the input only once both stages are full.
// The limit path (32 x length multiply, add, saturate) sets the cycle time.
// Synchronous active-low reset: no read pending, counters and limit zero, registers at defaults.
module serial_read_timeout_controller import srtc_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = LENGTH_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration writes
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [WORD_W-1:0]       cfg_wdata,
  // input items
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [LENGTH_WIDTH-1:0] in_read_length,
  input  logic [LENGTH_WIDTH-1:0] in_byte_count,
  // result items
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              out_status,
  output logic [LENGTH_WIDTH-1:0] out_bytes_done,
  output logic [WORD_W-1:0]       out_total_limit
);

  // Configuration registers; only sampled when a start item is processed.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.read_allowed     <= 1'b1;
      cfg_r.interval_timeout <= '0;
      cfg_r.total_multiplier <= '0;
      cfg_r.total_constant   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_READ_ALLOWED:     cfg_r.read_allowed     <= cfg_wdata[0];
        CFG_INTERVAL_TIMEOUT: cfg_r.interval_timeout <= cfg_wdata;
        CFG_TOTAL_MULTIPLIER: cfg_r.total_multiplier <= cfg_wdata;
        CFG_TOTAL_CONSTANT:   cfg_r.total_constant   <= cfg_wdata;
        default:              cfg_r                  <= cfg_r;
      endcase
    end
  end

  // Input register stage. The stage advances whenever the result register is
  // free or being emptied this cycle, so in_ready does not wait on a stall
  // unless both stages are full.
  logic                    s1_valid_r;
  op_t                     s1_op_r;
  logic [LENGTH_WIDTH-1:0] s1_len_r;
  logic [LENGTH_WIDTH-1:0] s1_cnt_r;
  logic                    adv;

  assign adv      = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r  <= op_t'(in_op);
      s1_len_r <= in_read_length;
      s1_cnt_r <= in_byte_count;
    end
  end

  // Total limit for the length held in the input stage.
  logic [WORD_W-1:0] lim;

  srtc_limit #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_limit (
    .cfg (cfg_r),
    .len (s1_len_r),
    .lim (lim)
  );

  // Event handling and read state; state commits when the item advances.
  status_t                 res_status;
  logic [LENGTH_WIDTH-1:0] res_bytes;
  logic [WORD_W-1:0]       res_limit;

  srtc_ctrl #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (adv),
    .op         (s1_op_r),
    .len        (s1_len_r),
    .cnt        (s1_cnt_r),
    .cfg        (cfg_r),
    .lim        (lim),
    .res_status (res_status),
    .res_bytes  (res_bytes),
    .res_limit  (res_limit)
  );

  // Result register: one result item per input item.
  logic                    out_valid_r;
  logic [2:0]              out_status_r;
  logic [LENGTH_WIDTH-1:0] out_bytes_r;
  logic [WORD_W-1:0]       out_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= res_status;
      out_bytes_r  <= res_bytes;
      out_limit_r  <= res_limit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_bytes_done  = out_bytes_r;
  assign out_total_limit = out_limit_r;

endmodule
